>>> hdl/vrd_pkg.sv
// vrd_pkg: shared widths, constants, the vector item type and the
// elaboration-time helpers (arctangent table entries, CORDIC gain root).
// No dependencies.
package vrd_pkg;

    // Default parameter values
    localparam int DATA_WIDTH_DEF    = 32;
    localparam int CORDIC_STAGES_DEF = 16;

    // Fixed internal formats
    localparam int FRAC_BITS   = 16;  // Q16.16 inputs
    localparam int GUARD_TOTAL = 60;  // data width plus guard bits
    localparam int WORK_W      = 64;  // guarded x/y datapath
    localparam int ANGLE_W     = 44;  // residual angle, radians in Q40
    localparam int ANGLE_EXT_W = 48;  // angle input extended to widest case
    localparam int TURN_W      = 32;  // whole-degree part of the angle
    localparam int RESID_W     = 23;  // residual in [-45, 45) degrees, Q16
    localparam int GAIN_W      = 30;  // gain correction factor, Q30

    localparam logic [63:0]        PI_Q40         = 64'd3454217648411;
    localparam logic signed [35:0] DEG_TO_RAD_Q40 = 36'sd19190098047;

    // One vector in flight: guarded x/y and remaining angle
    typedef struct packed {
        logic signed [WORK_W-1:0]  x;
        logic signed [WORK_W-1:0]  y;
        logic signed [ANGLE_W-1:0] z;
    } vrd_vec_t;

    // Restoring division, elaboration only
    function automatic logic [63:0] const_udiv(input logic [63:0] num,
                                               input logic [63:0] den);
        logic [63:0] rem;
        logic [63:0] quo;
        int          b;
        rem = '0;
        quo = '0;
        for (b = 63; b >= 0; b--)
        begin
            rem = {rem[62:0], num[b]};
            if (rem >= den)
            begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // atan(2^-idx) in Q40: series in Q60, rounded half up to Q40
    function automatic logic [63:0] atan_q40(input int idx);
        logic signed [63:0] sum;
        logic [63:0]        term;
        int                 k;
        int                 e;
        sum = '0;
        if (idx == 0)
        begin
            return (PI_Q40 + 64'd2) >> 2;
        end
        for (k = 0; k < 64; k++)
        begin
            e = 60 - idx * (2 * k + 1);
            if (e >= 0)
            begin
                term = const_udiv(64'd1 << e, 64'(2 * k + 1));
                if (k[0])
                    sum = sum - $signed(term);
                else
                    sum = sum + $signed(term);
            end
        end
        return ($unsigned(sum) + (64'd1 << 19)) >> 20;
    endfunction

    // floor(sqrt(prod(1 + 2^-2i))) in Q30
    function automatic logic [63:0] gain_root(input int stages);
        logic [63:0] p;
        logic [63:0] res;
        logic [63:0] cand;
        int          i;
        int          b;
        p   = 64'd1 << 60;
        res = '0;
        for (i = 0; i < stages; i++)
        begin
            p = p + (p >> (2 * i));
        end
        for (b = 31; b >= 0; b--)
        begin
            cand = res | (64'd1 << b);
            if (cand * cand <= p)
                res = cand;
        end
        if (res == 64'd0)
            res = 64'd1;
        return res;
    endfunction

endpackage

>>> hdl/vector_rotate_degrees_core.sv
// vector_rotate_degrees_core: rotates (x, y) counterclockwise by an angle in degrees.
// Stages from input transaction to output valid: 6 reduction stages, one register per
// CORDIC iteration, 5 gain stages.
// Throughput: one transaction per cycle; a stall only holds the stages behind a full one.
// Reset clears the valid bits only; data registers are not reset.
module vector_rotate_degrees_core #(
    parameter int  DATA_WIDTH    = vrd_pkg::DATA_WIDTH_DEF,
    parameter int  CORDIC_STAGES = vrd_pkg::CORDIC_STAGES_DEF,
    localparam int IN_TDATA_W    = ((3 * DATA_WIDTH + 7) / 8) * 8,
    localparam int OUT_TDATA_W   = ((2 * DATA_WIDTH + 7) / 8) * 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // vec_x, vec_y, angle_deg
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // rot_x, rot_y
    output logic [0:0]             m_tuser    // saturated
);
    import vrd_pkg::*;

    vrd_vec_t                chain_vec [CORDIC_STAGES+1];
    logic [CORDIC_STAGES:0]  chain_valid;
    logic [CORDIC_STAGES:0]  chain_ready;
    logic [DATA_WIDTH-1:0]   rot_x, rot_y;
    logic                    saturated;

    // angle reduction and quadrant fold
    vrd_reduce #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_reduce (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .vec_x     (s_tdata[DATA_WIDTH-1:0]),
        .vec_y     (s_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
        .angle_deg (s_tdata[3*DATA_WIDTH-1:2*DATA_WIDTH]),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_vec   (chain_vec[0])
    );

    // CORDIC iterations, one register stage each
    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cordic
        vrd_cordic_stage #(
            .STAGE (i)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_vec    (chain_vec[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_vec   (chain_vec[i+1])
        );
    end

    // gain correction, rounding and saturation
    vrd_gain #(
        .DATA_WIDTH    (DATA_WIDTH),
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_gain (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (chain_valid[CORDIC_STAGES]),
        .in_ready  (chain_ready[CORDIC_STAGES]),
        .in_vec    (chain_vec[CORDIC_STAGES]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .rot_x     (rot_x),
        .rot_y     (rot_y),
        .saturated (saturated)
    );

    // output packing, zero padded to whole bytes
    assign m_tdata    = OUT_TDATA_W'({rot_y, rot_x});
    assign m_tuser[0] = saturated;

endmodule

>>> hdl/vrd_reduce.sv
// vrd_reduce: angle reduction modulo 360, quadrant fold of x/y, and
// degree-to-radian conversion of the residual. Six register stages.
// Depends on vrd_pkg.
module vrd_reduce #(
    parameter int DATA_WIDTH = vrd_pkg::DATA_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [DATA_WIDTH-1:0] vec_x,
    input  logic signed [DATA_WIDTH-1:0] vec_y,
    input  logic signed [DATA_WIDTH-1:0] angle_deg,
    output logic                         out_valid,
    input  logic                         out_ready,
    output vrd_pkg::vrd_vec_t            out_vec
);
    import vrd_pkg::*;

    localparam int GUARD_BITS = GUARD_TOTAL - DATA_WIDTH;
    localparam int NUM_STAGES = 6;
    localparam int U_W        = TURN_W + 1;
    localparam int PROD_W     = 61;
    localparam int ZP_W       = 59;
    localparam int R_W        = 25;

    // 360 * 2^23 makes any 32-bit turn count non-negative
    localparam logic [U_W-1:0] TURN_OFFSET = 33'd3019898880;
    // ceil(2^36 / 45): exact quotient for 30-bit dividends
    localparam logic [30:0]    RECIP_45    = 31'd1527099484;
    localparam int             RECIP_SHIFT = 36;
    localparam logic [8:0]     DEG_TURN    = 9'd360;

    localparam logic [R_W:0] EIGHTH_TURN = 26'(45 << FRAC_BITS);
    localparam logic [R_W:0] QUARTER_1   = 26'(90 << FRAC_BITS);
    localparam logic [R_W:0] QUARTER_2   = 26'(180 << FRAC_BITS);
    localparam logic [R_W:0] QUARTER_3   = 26'(270 << FRAC_BITS);
    localparam logic [R_W:0] QUARTER_4   = 26'(360 << FRAC_BITS);

    localparam logic signed [ZP_W-1:0] ZP_ROUND = ZP_W'(1) <<< (FRAC_BITS - 1);

    typedef enum logic [1:0] {
        QUAD_0   = 2'd0,
        QUAD_90  = 2'd1,
        QUAD_180 = 2'd2,
        QUAD_270 = 2'd3
    } quad_t;

    logic [NUM_STAGES:1] vld_reg;
    logic [NUM_STAGES:1] adv;

    // stage registers
    logic signed [DATA_WIDTH-1:0] s1_x_reg, s1_y_reg;
    logic [U_W-1:0]               s1_u_reg;
    logic [FRAC_BITS-1:0]         s1_lo_reg;

    logic signed [DATA_WIDTH-1:0] s2_x_reg, s2_y_reg;
    logic [8:0]                   s2_u9_reg, s2_q9_reg;
    logic [FRAC_BITS-1:0]         s2_lo_reg;

    logic signed [DATA_WIDTH-1:0] s3_x_reg, s3_y_reg;
    logic [R_W-1:0]               s3_r_reg;

    logic signed [DATA_WIDTH-1:0] s4_x_reg, s4_y_reg;
    quad_t                        s4_quad_reg;
    logic signed [RESID_W-1:0]    s4_f_reg;

    logic signed [WORK_W-1:0]     s5_x_reg, s5_y_reg;
    logic signed [ZP_W-1:0]       s5_zp_reg;

    vrd_vec_t                     s6_vec_reg;

    // combinational next values
    logic signed [ANGLE_EXT_W-1:0] angle_ext;
    logic [TURN_W-1:0]             turns;
    logic [U_W-1:0]                s1_u_next;
    logic [PROD_W-1:0]             recip_prod;
    logic [8:0]                    s3_rem_next;
    logic [R_W:0]                  s4_t;
    logic signed [R_W:0]           s4_r;
    logic signed [R_W:0]           s4_f_full;
    quad_t                         s4_quad_next;
    logic signed [WORK_W-1:0]      x_scaled, y_scaled;
    logic signed [WORK_W-1:0]      s5_x_next, s5_y_next;
    logic signed [ZP_W-1:0]        s5_zp_next;
    logic signed [ZP_W-1:0]        z_rounded;

    // ready chain: a stage moves when empty or when the next one moves
    always_comb
    begin
        adv[NUM_STAGES] = !vld_reg[NUM_STAGES] || out_ready;
        for (int i = NUM_STAGES - 1; i >= 1; i--)
        begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    assign in_ready  = adv[1];
    assign out_valid = vld_reg[NUM_STAGES];
    assign out_vec   = s6_vec_reg;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[1])
                vld_reg[1] <= in_valid;
            for (int i = 2; i <= NUM_STAGES; i++)
            begin
                if (adv[i])
                    vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // stage 1: split angle into whole degrees and fraction, bias to non-negative
    assign angle_ext = ANGLE_EXT_W'(angle_deg);
    assign turns     = angle_ext[ANGLE_EXT_W-1:FRAC_BITS];
    assign s1_u_next = {turns[TURN_W-1], turns} + TURN_OFFSET;

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            s1_x_reg  <= vec_x;
            s1_y_reg  <= vec_y;
            s1_u_reg  <= s1_u_next;
            s1_lo_reg <= angle_ext[FRAC_BITS-1:0];
        end
    end

    // stage 2: quotient by 360 as (u / 8) * reciprocal of 45
    assign recip_prod = PROD_W'(s1_u_reg[U_W-1:3]) * PROD_W'(RECIP_45);

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            s2_x_reg  <= s1_x_reg;
            s2_y_reg  <= s1_y_reg;
            s2_u9_reg <= s1_u_reg[8:0];
            s2_q9_reg <= recip_prod[RECIP_SHIFT+8:RECIP_SHIFT];
            s2_lo_reg <= s1_lo_reg;
        end
    end

    // stage 3: remainder in whole degrees; only the low bits matter
    assign s3_rem_next = s2_u9_reg - 9'(s2_q9_reg * DEG_TURN);

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            s3_x_reg <= s2_x_reg;
            s3_y_reg <= s2_y_reg;
            s3_r_reg <= {s3_rem_next, s2_lo_reg};
        end
    end

    // stage 4: nearest quarter turn and residual in [-45, 45)
    assign s4_t = {1'b0, s3_r_reg} + EIGHTH_TURN;
    assign s4_r = $signed({1'b0, s3_r_reg});

    always_comb
    begin
        if (s4_t >= QUARTER_4)
        begin
            s4_quad_next = QUAD_0;
            s4_f_full    = s4_r - $signed(QUARTER_4);
        end
        else if (s4_t >= QUARTER_3)
        begin
            s4_quad_next = QUAD_270;
            s4_f_full    = s4_r - $signed(QUARTER_3);
        end
        else if (s4_t >= QUARTER_2)
        begin
            s4_quad_next = QUAD_180;
            s4_f_full    = s4_r - $signed(QUARTER_2);
        end
        else if (s4_t >= QUARTER_1)
        begin
            s4_quad_next = QUAD_90;
            s4_f_full    = s4_r - $signed(QUARTER_1);
        end
        else
        begin
            s4_quad_next = QUAD_0;
            s4_f_full    = s4_r;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            s4_x_reg    <= s3_x_reg;
            s4_y_reg    <= s3_y_reg;
            s4_quad_reg <= s4_quad_next;
            s4_f_reg    <= s4_f_full[RESID_W-1:0];
        end
    end

    // stage 5: add guard bits, fold quadrant exactly, residual times deg->rad
    assign x_scaled   = WORK_W'(s4_x_reg) <<< GUARD_BITS;
    assign y_scaled   = WORK_W'(s4_y_reg) <<< GUARD_BITS;
    assign s5_zp_next = ZP_W'(s4_f_reg) * ZP_W'(DEG_TO_RAD_Q40);

    always_comb
    begin
        case (s4_quad_reg)
            QUAD_90:
            begin
                s5_x_next = -y_scaled;
                s5_y_next = x_scaled;
            end
            QUAD_180:
            begin
                s5_x_next = -x_scaled;
                s5_y_next = -y_scaled;
            end
            QUAD_270:
            begin
                s5_x_next = y_scaled;
                s5_y_next = -x_scaled;
            end
            default:
            begin
                s5_x_next = x_scaled;
                s5_y_next = y_scaled;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            s5_x_reg  <= s5_x_next;
            s5_y_reg  <= s5_y_next;
            s5_zp_reg <= s5_zp_next;
        end
    end

    // stage 6: round the Q56 product to Q40 radians
    assign z_rounded = (s5_zp_reg + ZP_ROUND) >>> FRAC_BITS;

    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            s6_vec_reg.x <= s5_x_reg;
            s6_vec_reg.y <= s5_y_reg;
            s6_vec_reg.z <= z_rounded[ANGLE_W-1:0];
        end
    end

endmodule

>>> hdl/vrd_cordic_stage.sv
// vrd_cordic_stage: one registered CORDIC micro-rotation, shift fixed by STAGE.
// Depends on vrd_pkg.
module vrd_cordic_stage #(
    parameter int STAGE = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  vrd_pkg::vrd_vec_t in_vec,
    output logic              out_valid,
    input  logic              out_ready,
    output vrd_pkg::vrd_vec_t out_vec
);
    import vrd_pkg::*;

    localparam logic signed [ANGLE_W-1:0] ATAN_STEP = ANGLE_W'(atan_q40(STAGE));

    logic                      vld_reg;
    vrd_vec_t                  vec_reg;
    logic                      adv;
    logic signed [WORK_W-1:0]  x_in, y_in, dx, dy;
    logic signed [ANGLE_W-1:0] z_in;
    vrd_vec_t                  vec_next;

    assign adv       = !vld_reg || out_ready;
    assign in_ready  = adv;
    assign out_valid = vld_reg;
    assign out_vec   = vec_reg;

    // rotate toward zero residual angle
    assign x_in = in_vec.x;
    assign y_in = in_vec.y;
    assign z_in = in_vec.z;
    assign dx   = y_in >>> STAGE;
    assign dy   = x_in >>> STAGE;

    always_comb
    begin
        if (!z_in[ANGLE_W-1])
        begin
            vec_next.x = x_in - dx;
            vec_next.y = y_in + dy;
            vec_next.z = z_in - ATAN_STEP;
        end
        else
        begin
            vec_next.x = x_in + dx;
            vec_next.y = y_in - dy;
            vec_next.z = z_in + ATAN_STEP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (adv)
            vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            vec_reg <= vec_next;
    end

endmodule

>>> hdl/vrd_gain.sv
// vrd_gain: CORDIC gain correction, guard-bit removal with rounding and
// saturation to DATA_WIDTH. Five register stages, the last one is the output.
// Depends on vrd_pkg.
module vrd_gain #(
    parameter int DATA_WIDTH    = vrd_pkg::DATA_WIDTH_DEF,
    parameter int CORDIC_STAGES = vrd_pkg::CORDIC_STAGES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  vrd_pkg::vrd_vec_t     in_vec,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [DATA_WIDTH-1:0] rot_x,
    output logic [DATA_WIDTH-1:0] rot_y,
    output logic                  saturated
);
    import vrd_pkg::*;

    localparam int GUARD_BITS = GUARD_TOTAL - DATA_WIDTH;
    localparam int NUM_STAGES = 5;
    localparam int MAG_W      = 62;
    localparam int HP_W       = 62;
    localparam int LP_W       = 61;
    localparam int R_W        = 63;

    localparam logic [63:0] GAIN_ROOT = gain_root(CORDIC_STAGES);
    localparam logic [63:0] GAIN_FULL = ((64'd1 << 60) + GAIN_ROOT / 2) / GAIN_ROOT;
    localparam logic [GAIN_W-1:0] GAIN_K = GAIN_FULL[GAIN_W-1:0];

    localparam logic [LP_W-1:0]          LP_ROUND   = LP_W'(1) << (GAIN_W - 1);
    localparam logic signed [WORK_W-1:0] GUARD_HALF = WORK_W'(1) <<< (GUARD_BITS - 1);
    localparam logic [DATA_WIDTH-1:0]    LIM_MIN    = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic [DATA_WIDTH-1:0]    LIM_MAX    = ~LIM_MIN;

    logic [NUM_STAGES:1] vld_reg;
    logic [NUM_STAGES:1] adv;

    logic [MAG_W-1:0]         g1_mag_x_reg, g1_mag_y_reg;
    logic                     g1_neg_x_reg, g1_neg_y_reg;
    logic [HP_W-1:0]          g2_hp_x_reg, g2_hp_y_reg;
    logic [LP_W-1:0]          g2_lp_x_reg, g2_lp_y_reg;
    logic                     g2_neg_x_reg, g2_neg_y_reg;
    logic [R_W-1:0]           g3_r_x_reg, g3_r_y_reg;
    logic                     g3_neg_x_reg, g3_neg_y_reg;
    logic signed [WORK_W-1:0] g4_v_x_reg, g4_v_y_reg;
    logic [DATA_WIDTH-1:0]    g5_x_reg, g5_y_reg;
    logic                     g5_sat_reg;

    logic signed [WORK_W-1:0] x_in, y_in, abs_x, abs_y;
    logic signed [WORK_W-1:0] t_x, t_y;
    logic                     fits_x, fits_y;
    logic [DATA_WIDTH-1:0]    clamp_x, clamp_y;

    // ready chain
    always_comb
    begin
        adv[NUM_STAGES] = !vld_reg[NUM_STAGES] || out_ready;
        for (int i = NUM_STAGES - 1; i >= 1; i--)
        begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    assign in_ready  = adv[1];
    assign out_valid = vld_reg[NUM_STAGES];
    assign rot_x     = g5_x_reg;
    assign rot_y     = g5_y_reg;
    assign saturated = g5_sat_reg;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[1])
                vld_reg[1] <= in_valid;
            for (int i = 2; i <= NUM_STAGES; i++)
            begin
                if (adv[i])
                    vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // stage 1: sign and magnitude
    assign x_in  = in_vec.x;
    assign y_in  = in_vec.y;
    assign abs_x = x_in[WORK_W-1] ? -x_in : x_in;
    assign abs_y = y_in[WORK_W-1] ? -y_in : y_in;

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            g1_mag_x_reg <= abs_x[MAG_W-1:0];
            g1_mag_y_reg <= abs_y[MAG_W-1:0];
            g1_neg_x_reg <= x_in[WORK_W-1];
            g1_neg_y_reg <= y_in[WORK_W-1];
        end
    end

    // stage 2: partial products of magnitude high/low halves with the gain
    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            g2_hp_x_reg  <= HP_W'(g1_mag_x_reg[MAG_W-1:GAIN_W]) * HP_W'(GAIN_K);
            g2_hp_y_reg  <= HP_W'(g1_mag_y_reg[MAG_W-1:GAIN_W]) * HP_W'(GAIN_K);
            g2_lp_x_reg  <= LP_W'(g1_mag_x_reg[GAIN_W-1:0]) * LP_W'(GAIN_K);
            g2_lp_y_reg  <= LP_W'(g1_mag_y_reg[GAIN_W-1:0]) * LP_W'(GAIN_K);
            g2_neg_x_reg <= g1_neg_x_reg;
            g2_neg_y_reg <= g1_neg_y_reg;
        end
    end

    // stage 3: combine, low part rounded half up at Q30
    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            g3_r_x_reg   <= R_W'(g2_hp_x_reg) + R_W'((g2_lp_x_reg + LP_ROUND) >> GAIN_W);
            g3_r_y_reg   <= R_W'(g2_hp_y_reg) + R_W'((g2_lp_y_reg + LP_ROUND) >> GAIN_W);
            g3_neg_x_reg <= g2_neg_x_reg;
            g3_neg_y_reg <= g2_neg_y_reg;
        end
    end

    // stage 4: restore sign and add guard rounding offset in one add
    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            g4_v_x_reg <= g3_neg_x_reg ? (GUARD_HALF - $signed({1'b0, g3_r_x_reg}))
                                       : ($signed({1'b0, g3_r_x_reg}) + GUARD_HALF);
            g4_v_y_reg <= g3_neg_y_reg ? (GUARD_HALF - $signed({1'b0, g3_r_y_reg}))
                                       : ($signed({1'b0, g3_r_y_reg}) + GUARD_HALF);
        end
    end

    // stage 5: drop guard bits, clamp to the output range
    assign t_x    = g4_v_x_reg >>> GUARD_BITS;
    assign t_y    = g4_v_y_reg >>> GUARD_BITS;
    assign fits_x = (&t_x[WORK_W-1:DATA_WIDTH-1]) || !(|t_x[WORK_W-1:DATA_WIDTH-1]);
    assign fits_y = (&t_y[WORK_W-1:DATA_WIDTH-1]) || !(|t_y[WORK_W-1:DATA_WIDTH-1]);
    assign clamp_x = fits_x ? t_x[DATA_WIDTH-1:0] : (t_x[WORK_W-1] ? LIM_MIN : LIM_MAX);
    assign clamp_y = fits_y ? t_y[DATA_WIDTH-1:0] : (t_y[WORK_W-1] ? LIM_MIN : LIM_MAX);

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            g5_x_reg   <= clamp_x;
            g5_y_reg   <= clamp_y;
            g5_sat_reg <= !fits_x || !fits_y;
        end
    end

endmodule

>>> verif/vrd_rotation_checker.sv
`timescale 1ns / 1ps
// vrd_rotation_checker: watches both stream channels of vector_rotate_degrees_core,
// predicts each rotated vector from the accepted input, and compares field by field.
// Depends on vrd_pkg for the default width and stage count.
module vrd_rotation_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [95:0] s_tdata,    // vec_x, vec_y, angle_deg
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,    // rot_x, rot_y
    input  logic [0:0]  m_tuser,    // saturated
    output int          mismatch_count,
    output int          rotations_in_flight
);

    localparam int     STAGES      = vrd_pkg::CORDIC_STAGES_DEF;
    localparam int     GUARD       = 60 - vrd_pkg::DATA_WIDTH_DEF;
    localparam longint FULL_TURN   = longint'(360) <<< 16;
    localparam longint QUARTER     = longint'(90) <<< 16;
    localparam longint EIGHTH      = longint'(45) <<< 16;
    localparam longint PI_Q40      = 64'sd3454217648411;
    localparam longint DEG_RAD_Q40 = 64'sd19190098047;
    localparam longint WORD_MAX    = 64'sd2147483647;
    localparam longint WORD_MIN    = -64'sd2147483648;

    typedef enum logic [1:0] {QUAD_0, QUAD_90, QUAD_180, QUAD_270} quadrant_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic               sat;
    } rotated_vec_t;

    longint          arctan_q40 [STAGES];
    logic [63:0]     gain_k;
    rotated_vec_t    expected_rotations [$];

    // Arctangent table and CORDIC gain correction, built once at time zero
    initial
    begin : build_tables
        logic [63:0] prod;
        logic [63:0] root;
        logic [63:0] rem;
        logic [63:0] bitv;
        logic [63:0] term;
        longint      series;
        int          i;
        int          k;
        int          e;
        for (i = 0; i < STAGES; i++)
        begin
            if (i == 0)
            begin
                arctan_q40[i] = (PI_Q40 + 2) / 4;
            end
            else
            begin
                series = 0;
                for (k = 0; k < 64; k++)
                begin
                    e = 60 - i * (2 * k + 1);
                    if (e >= 0)
                    begin
                        term   = (64'd1 << e) / 64'(2 * k + 1);
                        series = k[0] ? series - longint'(term) : series + longint'(term);
                    end
                end
                arctan_q40[i] = (series + (64'sd1 <<< 19)) >>> 20;
            end
        end
        // product of (1 + 2^-2i) in Q60, integer square root to Q30
        prod = 64'd1 << 60;
        for (i = 0; i < STAGES; i++)
            prod = prod + (prod >> (2 * i));
        root = '0;
        rem  = prod;
        bitv = 64'd1 << 62;
        while (bitv > rem)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (rem >= root + bitv)
            begin
                rem  = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
            begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        if (root == 0)
            root = 1;
        gain_k = ((64'd1 << 60) + root / 2) / root;
    end

    // Gain correction with rounding on the magnitude, then guard bits dropped
    function automatic longint gain_scale(input longint v);
        logic [63:0] mag;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [63:0] prod;
        longint      signed_prod;
        mag  = (v < 0) ? -v : v;
        hi   = mag >> 30;
        lo   = mag & ((64'd1 << 30) - 1);
        prod = hi * gain_k + ((lo * gain_k + (64'd1 << 29)) >> 30);
        signed_prod = (v < 0) ? -$signed(prod) : $signed(prod);
        return (signed_prod + (64'sd1 <<< (GUARD - 1))) >>> GUARD;
    endfunction

    // Expected rotated vector for one input transaction
    function automatic rotated_vec_t rotate_by_degrees(input logic signed [31:0] vx,
                                                       input logic signed [31:0] vy,
                                                       input logic signed [31:0] ang);
        longint       x;
        longint       y;
        longint       z;
        longint       t;
        longint       r;
        longint       q;
        longint       f;
        longint       dx;
        longint       dy;
        quadrant_t    quad;
        rotated_vec_t res;
        int           i;
        x = longint'(vx) <<< GUARD;
        y = longint'(vy) <<< GUARD;
        // reduce to [0, 360), split into quarter turns plus residual in [-45, 45)
        r = longint'(ang) % FULL_TURN;
        if (r < 0)
            r = r + FULL_TURN;
        q    = (r + EIGHTH) / QUARTER;
        f    = r - q * QUARTER;
        quad = quadrant_t'(q[1:0]);
        case (quad)
            QUAD_90:
            begin
                t = x;
                x = -y;
                y = t;
            end
            QUAD_180:
            begin
                x = -x;
                y = -y;
            end
            QUAD_270:
            begin
                t = x;
                x = y;
                y = -t;
            end
            default:
            begin
            end
        endcase
        z = (f * DEG_RAD_Q40 + (64'sd1 <<< 15)) >>> 16;
        for (i = 0; i < STAGES; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - arctan_q40[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + arctan_q40[i];
            end
        end
        x = gain_scale(x);
        y = gain_scale(y);
        res.sat = 1'b0;
        if (x > WORD_MAX || x < WORD_MIN || y > WORD_MAX || y < WORD_MIN)
            res.sat = 1'b1;
        if (x > WORD_MAX)
            x = WORD_MAX;
        if (x < WORD_MIN)
            x = WORD_MIN;
        if (y > WORD_MAX)
            y = WORD_MAX;
        if (y < WORD_MIN)
            y = WORD_MIN;
        res.x = x[31:0];
        res.y = y[31:0];
        return res;
    endfunction

    initial
    begin
        mismatch_count      = 0;
        rotations_in_flight = 0;
    end

    // Sample both channels at the edge; outputs first, then the new input
    always @(posedge clk)
    begin : watch_channels
        rotated_vec_t exp_rot;
        logic         bad;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_rotations.size() == 0)
                begin
                    $display(
                        "%0t: output transaction with nothing expected, actual x=%h y=%h sat=%b",
                        $time, m_tdata[31:0], m_tdata[63:32], m_tuser[0]);
                    mismatch_count = mismatch_count + 1;
                end
                else
                begin
                    exp_rot = expected_rotations.pop_front();
                    bad     = 1'b0;
                    if (m_tdata[31:0] !== exp_rot.x)
                    begin
                        $display("%0t: rot_x mismatch, expected %h, actual %h",
                                 $time, exp_rot.x, m_tdata[31:0]);
                        bad = 1'b1;
                    end
                    if (m_tdata[63:32] !== exp_rot.y)
                    begin
                        $display("%0t: rot_y mismatch, expected %h, actual %h",
                                 $time, exp_rot.y, m_tdata[63:32]);
                        bad = 1'b1;
                    end
                    if (m_tuser[0] !== exp_rot.sat)
                    begin
                        $display("%0t: saturated mismatch, expected %b, actual %b",
                                 $time, exp_rot.sat, m_tuser[0]);
                        bad = 1'b1;
                    end
                    if (bad)
                        mismatch_count = mismatch_count + 1;
                end
            end
            if (s_tvalid && s_tready)
                expected_rotations.push_back(rotate_by_degrees(s_tdata[31:0], s_tdata[63:32],
                                                               s_tdata[95:64]));
            rotations_in_flight <= expected_rotations.size();
        end
    end

endmodule

>>> verif/vector_rotate_degrees_core_test.sv
`timescale 1ns / 1ps
// vector_rotate_degrees_core_test: clock, reset and stream stimulus for the rotator,
// with random idling on both sides and one long output hold-off.
// Depends on vector_rotate_degrees_core, vrd_pkg and vrd_rotation_checker.
module vector_rotate_degrees_core_test;

    localparam int          DEG  = 65536;  // one degree in Q16.16
    localparam logic [31:0] MAXV = 32'h7FFF_FFFF;
    localparam logic [31:0] MINV = 32'h8000_0000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;     // vec_x, vec_y, angle_deg
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;     // rot_x, rot_y
    logic [0:0]  m_tuser;     // saturated

    int   mismatch_count;
    int   rotations_in_flight;
    int   send_idle_pct;
    int   recv_idle_pct;
    logic hold_trigger;

    vector_rotate_degrees_core uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    vrd_rotation_checker checker_i (
        .clk                 (clk),
        .rst_n               (rst_n),
        .s_tvalid            (s_tvalid),
        .s_tready            (s_tready),
        .s_tdata             (s_tdata),
        .m_tvalid            (m_tvalid),
        .m_tready            (m_tready),
        .m_tdata             (m_tdata),
        .m_tuser             (m_tuser),
        .mismatch_count      (mismatch_count),
        .rotations_in_flight (rotations_in_flight)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Overall limit on run time
    initial
    begin
        #3000000;
        $display("** vector_rotate_degrees_core: FAILED **");
        $finish;
    end

    // Offer one vector, with random idle cycles first, and hold it until taken
    task automatic send_vec(input logic [31:0] vx, input logic [31:0] vy,
                            input logic [31:0] ang);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ang, vy, vx};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Coordinate: full range, scaled down, near the extremes, or mid-sized
    function automatic logic [31:0] rand_coord();
        logic signed [31:0] v;
        v = $urandom();
        case ($urandom_range(3))
            0: return v;
            1: return v >>> $urandom_range(30, 8);
            2: return ($urandom_range(1) ? MAXV : MINV) ^ $urandom_range(255);
            default: return v >>> 12;
        endcase
    endfunction

    // Receiver: random back-pressure, plus one long hold-off on request
    initial
    begin : receiver
        logic hold_done;
        int   n;
        hold_done = 1'b0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_trigger && !hold_done)
            begin
                hold_done = 1'b1;
                for (n = 0; n < 400; n++)
                begin
                    m_tready <= 1'b0;
                    @(posedge clk);
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin : stimulus
        logic [31:0] vx;
        logic [31:0] vy;
        logic [31:0] ang;
        int          phase;
        int          n;
        send_idle_pct = 20;
        recv_idle_pct = 54;
        hold_trigger  = 1'b0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, quarter turns, residual boundaries, clamping
        send_vec(1 * DEG, 0, 0);
        send_vec(0, 1 * DEG, 90 * DEG);
        send_vec(MAXV, 0, 0);
        send_vec(MINV, 0, 0);
        send_vec(MINV, 0, 180 * DEG);
        send_vec(0, MINV, 270 * DEG);
        send_vec(MAXV, MAXV, 45 * DEG);
        send_vec(MINV, MINV, -45 * DEG);
        send_vec(100 * DEG, -50 * DEG, 45 * DEG - 1);
        send_vec(100 * DEG, -50 * DEG, 315 * DEG);
        send_vec(-7 * DEG, 3 * DEG, 360 * DEG);
        send_vec(-7 * DEG, 3 * DEG, -360 * DEG);
        send_vec(5 * DEG, 5 * DEG, -90 * DEG);
        send_vec(5 * DEG, 5 * DEG, MAXV);
        send_vec(5 * DEG, 5 * DEG, MINV);
        send_vec(12345, -6789, -1);
        send_vec(12345, -6789, 1);
        send_vec(0, 0, 137 * DEG);
        send_vec(MAXV, MINV, 135 * DEG);
        send_vec(-1, -1, 225 * DEG);
        send_vec(1000 * DEG, 2000 * DEG, -135 * DEG);
        send_vec(MINV, MAXV, -180 * DEG);
        send_vec(30000 * DEG, 0, 30 * DEG);

        // Random: receiver-heavy idling, then sender-heavy, then none
        for (phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 20 : (phase == 1) ? 54 : 0;
            recv_idle_pct = (phase == 0) ? 54 : (phase == 1) ? 20 : 0;
            for (n = 0; n < 483; n++)
            begin
                if (phase == 2 && n == 150)
                    hold_trigger = 1'b1;
                vx = rand_coord();
                vy = rand_coord();
                case ($urandom_range(4))
                    0: ang = $urandom();
                    1: ang = ($urandom_range(16) - 8) * 45 * DEG + $urandom_range(6) - 3;
                    2: ang = $urandom_range(1440 * DEG) - 720 * DEG;
                    3: ang = ($urandom_range(1) ? MAXV : MINV) ^ $urandom_range(3);
                    default: ang = $urandom() >> $urandom_range(31);
                endcase
                send_vec(vx, vy, ang);
            end
        end
        s_tvalid <= 1'b0;

        // Drain, then allow for the pipeline latency
        @(posedge clk);
        while (rotations_in_flight != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (rotations_in_flight != 0)
            $display("%0t: %0d expected results never arrived", $time, rotations_in_flight);
        if (mismatch_count == 0 && rotations_in_flight == 0)
            $display("** vector_rotate_degrees_core: PASSED **");
        else
            $display("** vector_rotate_degrees_core: FAILED **");
        $finish;
    end

endmodule

>>> vector_rotate_degrees_core.f
hdl/vrd_pkg.sv
hdl/vrd_reduce.sv
hdl/vrd_cordic_stage.sv
hdl/vrd_gain.sv
hdl/vector_rotate_degrees_core.sv
verif/vrd_rotation_checker.sv
verif/vector_rotate_degrees_core_test.sv
